[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/pls_pkg.sv]
// ---------------------------------------------------------------------------
// Positional list store package
// Request and response types, operation and status codes, and the cell
// update codes shared by the list store modules.
// ---------------------------------------------------------------------------
package pls_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 6;
    localparam int CAP_W  = 7;
    localparam int FILL_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_GET    = 2'd1,
        FN_DELETE = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_POS  = 2'd2,
        ST_PAST_LEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_FROM_PREV = 2'd2,
        CELL_FROM_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_func              func;
        logic [POS_W-1:0]   position;
        logic [WORD_W-1:0]  word_in;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [WORD_W-1:0]  word_out;
        logic [FILL_W-1:0]  fill_after;
    } t_rsp;

endpackage

[sv/positional_list_store.sv]
// A result strobes on o_valid once its request has passed r_v1 and then r_valid.
// Throughput: one request per cycle; o_busy stays low, since the row of cells
// shifts the entries from the request position up in the cycle a request is
// accepted and the read combiner is pipelined.
// Reset (synchronous, active low) empties the list, sets the capacity to 64 and
// drops any result in flight; stored words are not cleared.
// ---------------------------------------------------------------------------
// Positional list store
// Ordered list of words held in a row of cells, with insert, get, delete and
// clear requests and a configurable capacity.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_store
    import pls_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_req             i_req,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output t_rsp             o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CAP_W-1:0] r_cap;

    logic             w_acc;
    t_status          n_status;
    logic             w_ins_go;
    logic             w_del_go;
    logic             w_rd_go;
    logic [CMP_W-1:0] w_sel_pos;
    logic [CMP_W-1:0] w_fill_x;
    logic [CMP_W-1:0] w_cap_eff;
    logic [CMP_W-1:0] w_pos_x;

    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_tap  [DEPTH];
    logic [WORD_W-1:0] w_rd_word;

    logic              r_v1;
    t_status           r_stat1;
    logic [FILL_W-1:0] r_fill1;
    logic              r_valid;
    t_rsp              r_rsp;

    assign o_busy = 1'b0;
    assign w_acc  = i_start & ~o_busy;

    // Request decode: status, new length and where the row shifts.
    always_comb begin
        w_fill_x  = CMP_W'(r_fill);
        w_cap_eff = (CMP_W'(r_cap) > DEPTH_C) ? DEPTH_C : CMP_W'(r_cap);
        w_pos_x   = CMP_W'(i_req.position);
        n_status  = ST_OK;
        n_fill    = r_fill;
        w_ins_go  = 1'b0;
        w_del_go  = 1'b0;
        w_rd_go   = 1'b0;
        w_sel_pos = w_pos_x;
        if (w_acc) begin
            unique case (i_req.func)
                FN_INSERT: begin
                    if (w_fill_x >= w_cap_eff) begin
                        n_status = ST_FULL;
                    end else if (w_pos_x >= w_cap_eff) begin
                        n_status = ST_BAD_POS;
                    end else begin
                        w_ins_go  = 1'b1;
                        // A position past the end appends.
                        w_sel_pos = (w_pos_x > w_fill_x) ? w_fill_x : w_pos_x;
                        n_fill    = r_fill + CNT_W'(1);
                    end
                end
                FN_GET, FN_DELETE: begin
                    if (w_pos_x >= w_fill_x) begin
                        n_status = ST_PAST_LEN;
                    end else begin
                        w_rd_go = 1'b1;
                        if (i_req.func == FN_DELETE) begin
                            w_del_go = 1'b1;
                            n_fill   = r_fill - CNT_W'(1);
                        end
                    end
                end
                FN_CLEAR: begin
                    n_fill = '0;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        t_cell_op          w_op;
        logic              w_sel;
        logic [WORD_W-1:0] w_prev;
        logic [WORD_W-1:0] w_next;

        always_comb begin
            w_op = CELL_HOLD;
            if (w_ins_go) begin
                if (CMP_W'(i) > w_sel_pos) begin
                    w_op = CELL_FROM_PREV;
                end else if (CMP_W'(i) == w_sel_pos) begin
                    w_op = CELL_LOAD;
                end
            end else if (w_del_go && (CMP_W'(i) >= w_sel_pos)) begin
                w_op = CELL_FROM_NEXT;
            end
        end

        assign w_sel  = w_rd_go && (CMP_W'(i) == w_sel_pos);
        assign w_prev = (i == 0) ? i_req.word_in : w_word[(i == 0) ? 0 : i - 1];
        assign w_next = (i == DEPTH - 1) ? w_word[i] : w_word[(i == DEPTH - 1) ? i : i + 1];

        pls_cell u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_new  (i_req.word_in),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_sel  (w_sel),
            .o_word (w_word[i]),
            .o_tap  (w_tap[i])
        );
    end

    pls_read_or #(
        .N_TAPS (DEPTH)
    ) u_read_or (
        .i_clk  (i_clk),
        .i_taps (w_tap),
        .o_word (w_rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_cap   <= CAP_RESET;
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_v1    <= w_acc;
            r_valid <= r_v1;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Response fields travel alongside the read data through the combiner.
    always_ff @(posedge i_clk) begin
        r_stat1 <= n_status;
        r_fill1 <= FILL_W'(n_fill);
        r_rsp.status     <= r_stat1;
        r_rsp.word_out   <= w_rd_word;
        r_rsp.fill_after <= r_fill1;
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    `ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, CMP_W'(r_fill) <= DEPTH_C)
    `ASSERT_NEXT(a_fill_idle, i_clk, i_rst_n, !w_acc, $stable(r_fill))
    `ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, r_v1, o_valid)
    `ASSERT_IMPLIES(a_fail_zero, i_clk, i_rst_n,
                    o_valid && (o_rsp.status != ST_OK), o_rsp.word_out == '0)

endmodule

[sv/pls_cell.sv]
// ---------------------------------------------------------------------------
// List store cell
// Holds one list entry. Each cycle it keeps its word, loads the new word, or
// takes the word of its lower or upper neighbor. Drives a gated read tap.
// ---------------------------------------------------------------------------
module pls_cell
    import pls_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_op          i_op,
    input  logic [WORD_W-1:0] i_new,
    input  logic [WORD_W-1:0] i_prev,
    input  logic [WORD_W-1:0] i_next,
    input  logic              i_sel,
    output logic [WORD_W-1:0] o_word,
    output logic [WORD_W-1:0] o_tap
);

    logic [WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_HOLD:      r_word <= r_word;
            CELL_LOAD:      r_word <= i_new;
            CELL_FROM_PREV: r_word <= i_prev;
            CELL_FROM_NEXT: r_word <= i_next;
        endcase
    end

    assign o_word = r_word;
    // Unselected cells drive zero so the taps can simply be ORed together.
    assign o_tap  = i_sel ? r_word : '0;

endmodule

[sv/pls_read_or.sv]
// ---------------------------------------------------------------------------
// List store read combiner
// ORs the gated read taps of all cells in two steps: registered groups of
// eight taps, then one OR over the group registers.
// ---------------------------------------------------------------------------
module pls_read_or
    import pls_pkg::*;
#(
    parameter int N_TAPS = 64
)
(
    input  logic              i_clk,
    input  logic [WORD_W-1:0] i_taps [N_TAPS],
    output logic [WORD_W-1:0] o_word
);

    localparam int GRP   = 8;
    localparam int N_GRP = (N_TAPS + GRP - 1) / GRP;

    logic [WORD_W-1:0] r_grp [N_GRP];
    logic [WORD_W-1:0] n_grp [N_GRP];

    always_comb begin
        for (int g = 0; g < N_GRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < N_TAPS) begin
                    n_grp[g] = n_grp[g] | i_taps[g * GRP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < N_GRP; g++) begin
            o_word = o_word | r_grp[g];
        end
    end

endmodule
